[rtl/prime_modulus_lcg_random_defines.svh]
// Assertion macros shared by the generator RTL.
`ifndef PRIME_MODULUS_LCG_RANDOM_DEFINES_SVH
`define PRIME_MODULUS_LCG_RANDOM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define PMLCG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define PMLCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pmlcg_pkg.sv]
// Package: constants, kind codes and multiplier table of the LCG.
package pmlcg_pkg;

	localparam logic [31:0] MODULUS    = 32'hFFFFFFFB;
	localparam logic [31:0] MULT_RESET = 32'h52F690D5;

	localparam logic [2:0] KIND_SEED = 3'd0;
	localparam logic [2:0] KIND_WORD = 3'd1;
	localparam logic [2:0] KIND_HALF = 3'd2;
	localparam logic [2:0] KIND_LEAD = 3'd3;
	localparam logic [2:0] KIND_TAIL = 3'd4;

	function automatic logic [31:0] mult_lookup(input logic [2:0] idx);
		logic [31:0] m;
		unique case (idx)
			3'd0: m = 32'h52F690D5;
			3'd1: m = 32'h534D7DDE;
			3'd2: m = 32'h5B71A70F;
			3'd3: m = 32'h66793320;
			3'd4: m = 32'h9B7E5ED5;
			3'd5: m = 32'hA465265E;
			3'd6: m = 32'hA53F1D11;
			3'd7: m = 32'hB154430F;
			default: m = MULT_RESET;
		endcase
		return m;
	endfunction

endpackage

[rtl/pmlcg_if.sv]
// Channel interfaces: command items in, draw items out.
interface pmlcg_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] seed;

	modport source (output valid, output kind, output seed, input ready);
	modport sink   (input valid, input kind, input seed, output ready);
endinterface

interface pmlcg_draw_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[rtl/pmlcg_step.sv]
// One LCG step: (base + 1) * factor mod 2^32-5, folded without a divider.
module pmlcg_step (
	input  logic [31:0] base,
	input  logic [31:0] factor,
	output logic [31:0] result
);
	import pmlcg_pkg::*;

	logic [63:0] prod;
	logic [34:0] fold1;
	logic [32:0] fold2;
	logic [32:0] wrap;

	// (base+1)*factor = base*factor + factor; 2^32 == 5 mod p
	assign prod  = {32'b0, base} * {32'b0, factor};
	assign fold1 = {3'b0, prod[31:0]} + {1'b0, prod[63:32], 2'b00}
		+ {3'b0, prod[63:32]} + {3'b0, factor};
	// top bits at most 6, so fold2 < 2p
	assign fold2 = {1'b0, fold1[31:0]} + {28'b0, fold1[34:32], 2'b00}
		+ {30'b0, fold1[34:32]};
	assign wrap  = fold2 - {1'b0, MODULUS};

	assign result = (fold2 >= {1'b0, MODULUS}) ? wrap[31:0] : fold2[31:0];

endmodule

[rtl/prime_modulus_lcg_random.sv]
// Top level: Lehmer-style LCG, modulus 2^32-5, seed and four draw kinds.
// A draw passes the command stage register, then the result register, before it reaches the draw port.
// Throughput: one item per cycle unless a pending draw waits on draw.ready; the limit is the
// multiply-and-fold step in pmlcg_step, which closes the state loop combinationally.
// Reset (arst_n, async, low): current and mask clear, multiplier is the first table entry.
`include "prime_modulus_lcg_random_defines.svh"

module prime_modulus_lcg_random (
	input  logic          clk,
	input  logic          arst_n,
	pmlcg_cmd_if.sink     cmd,
	pmlcg_draw_if.source  draw
);
	import pmlcg_pkg::*;

	// command stage
	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [31:0] seed_s1;

	// generator state
	logic [31:0] current_q;
	logic [31:0] mult_q;
	logic [31:0] mask_q;

	// result register
	logic        valid_s2;
	logic [31:0] value_s2;

	logic        is_seed;
	logic        is_draw;
	logic        out_free;
	logic        advance;
	logic [31:0] seed_mult;
	logic [31:0] step_base;
	logic [31:0] step_factor;
	logic [31:0] step_next;
	logic [31:0] masked;
	logic [31:0] slice;

	assign is_seed = (kind_s1 == KIND_SEED);
	assign is_draw = (kind_s1 == KIND_WORD) || (kind_s1 == KIND_HALF)
		|| (kind_s1 == KIND_LEAD) || (kind_s1 == KIND_TAIL);

	// Seeds and unused kinds never need the result slot, so they never stall.
	assign out_free  = !valid_s2 || draw.ready;
	assign advance   = valid_s1 && (!is_draw || out_free);
	assign cmd.ready = !valid_s1 || advance;

	// A seed steps from the seed itself with its freshly chosen multiplier.
	assign seed_mult   = mult_lookup(seed_s1[2:0]);
	assign step_base   = is_seed ? seed_s1 : current_q;
	assign step_factor = is_seed ? seed_mult : mult_q;

	pmlcg_step u_step (
		.base   (step_base),
		.factor (step_factor),
		.result (step_next)
	);

	assign masked = step_next ^ mask_q;

	always_comb begin
		unique case (kind_s1)
			KIND_WORD: slice = masked;
			KIND_HALF: slice = {16'b0, masked[23:8]};
			KIND_LEAD: slice = {24'b0, masked[21:14]};
			KIND_TAIL: slice = {24'b0, masked[19:12]};
			default:   slice = masked;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1 <= cmd.kind;
			seed_s1 <= cmd.seed;
		end
	end

	// State moves only as an item leaves the command stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= '0;
			mult_q    <= MULT_RESET;
			mask_q    <= '0;
		end else if (advance && is_seed) begin
			// mask takes the same stepped value, so it equals the new current
			current_q <= step_next;
			mult_q    <= seed_mult;
			mask_q    <= step_next;
		end else if (advance && is_draw) begin
			current_q <= step_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && is_draw;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_draw) begin
			value_s2 <= slice;
		end
	end

	assign draw.valid = valid_s2;
	assign draw.value = value_s2;

	`PMLCG_ASSERT_NEXT(a_seed_sets_mask, advance && is_seed, mask_q == current_q, "mask differs from current after seed")
	`PMLCG_ASSERT_NEXT(a_current_reduced, advance && (is_seed || is_draw), current_q < MODULUS, "current not reduced")
	`PMLCG_ASSERT_NOW(a_no_overwrite, valid_s2 && !draw.ready, !(advance && is_draw), "pending draw overwritten")
	`PMLCG_ASSERT_NEXT(a_unused_kind_idle, advance && !is_seed && !is_draw, $stable(current_q) && $stable(mult_q) && $stable(mask_q), "unused kind changed state")

endmodule
